// ===== sv/msfm_pkg.sv =====
// Shared types, codes and constants of the multi-signature first-match scan unit.
package msfm_pkg;

  localparam int NUM_SLOTS_DEF   = 32;
  localparam int MAX_SIG_LEN_DEF = 16;
  localparam int POS_W           = 17;
  localparam int OFFSET_W        = 16;
  localparam int SLOT_FIELD_W    = 5;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [15:0] SCAN_LENGTH_RESET = 16'hFFFE;

  localparam logic [1:0] FUNC_SIG_BYTE = 2'd0;
  localparam logic [1:0] FUNC_SIG_LEN  = 2'd1;
  localparam logic [1:0] FUNC_STREAM   = 2'd2;

  localparam logic REG_PATTERN_COUNT = 1'b0;
  localparam logic REG_SCAN_LENGTH   = 1'b1;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_SIG_BYTE,
    CMD_SIG_LEN,
    CMD_STREAM
  } cmd_kind_e_t;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] slot;
    logic [3:0] byte_position;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  match_slot;
    logic [15:0] match_offset;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e_t kind;
    logic [4:0]  slot;
    logic [3:0]  bpos;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  pattern_count;
    logic [15:0] scan_length;
  } cfg_t;

endpackage

// ===== sv/msfm_front.sv =====
// Front end: input register that decodes and range-checks each beat into a command.
module msfm_front #(
  parameter int NUM_SLOTS   = msfm_pkg::NUM_SLOTS_DEF,
  parameter int MAX_SIG_LEN = msfm_pkg::MAX_SIG_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  msfm_pkg::in_item_t item,
  output logic              push_valid,
  output msfm_pkg::cmd_t    push_cmd,
  input  logic              q_ready
);

  logic           f_valid;
  msfm_pkg::cmd_t f_cmd;
  msfm_pkg::cmd_t dec;

  always_comb begin
    dec.slot = item.slot;
    dec.bpos = item.byte_position;
    dec.data = item.data_byte;
    dec.last = item.last;
    dec.kind = msfm_pkg::CMD_NOP;
    unique case (item.func)
      msfm_pkg::FUNC_SIG_BYTE: begin
        if (int'(item.slot) < NUM_SLOTS && int'(item.byte_position) < MAX_SIG_LEN)
          dec.kind = msfm_pkg::CMD_SIG_BYTE;
      end
      msfm_pkg::FUNC_SIG_LEN: begin
        if (int'(item.slot) < NUM_SLOTS) dec.kind = msfm_pkg::CMD_SIG_LEN;
        if (int'(item.data_byte) > MAX_SIG_LEN) dec.data = 8'(MAX_SIG_LEN);
      end
      msfm_pkg::FUNC_STREAM: dec.kind = msfm_pkg::CMD_STREAM;
      default: dec.kind = msfm_pkg::CMD_NOP;
    endcase
  end

  assign item_stall = f_valid && !q_ready;
  assign push_valid = f_valid;
  assign push_cmd   = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!item_stall) begin
      f_valid <= item_valid && (dec.kind != msfm_pkg::CMD_NOP);
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) f_cmd <= dec;
  end

endmodule

// ===== sv/msfm_queue.sv =====
// Short command queue between the front end and the scan engine.
module msfm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  msfm_pkg::cmd_t push_cmd,
  output logic           ready,
  output logic           valid,
  output msfm_pkg::cmd_t data,
  input  logic           pop
);

  localparam int PTR_W = (msfm_pkg::QUEUE_DEPTH > 1) ? $clog2(msfm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(msfm_pkg::QUEUE_DEPTH + 1);

  msfm_pkg::cmd_t   mem [msfm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ready   = count != CNT_W'(msfm_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign data    = mem[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (int'(wr_ptr) == msfm_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)
        rd_ptr <= (int'(rd_ptr) == msfm_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (!do_push && do_pop) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

endmodule

// ===== sv/msfm_back.sv =====
// Scan engine: signature store, byte window, parallel compare, winner pick and result register.
module msfm_back #(
  parameter int NUM_SLOTS   = msfm_pkg::NUM_SLOTS_DEF,
  parameter int MAX_SIG_LEN = msfm_pkg::MAX_SIG_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  msfm_pkg::cmd_t     q_cmd,
  output logic               pop,
  input  msfm_pkg::cfg_t     cfg,
  output logic               result_valid,
  input  logic               result_stall,
  output msfm_pkg::out_item_t result
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LEN_W  = $clog2(MAX_SIG_LEN + 1);
  localparam int WIN_W  = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
  localparam int POS_W  = msfm_pkg::POS_W;
  localparam int OFF_W  = msfm_pkg::OFFSET_W;

  logic [7:0]       sig [NUM_SLOTS][MAX_SIG_LEN];
  logic [LEN_W-1:0] lens [NUM_SLOTS];
  logic [7:0]       win [MAX_SIG_LEN];
  logic [7:0]       win_next [MAX_SIG_LEN];
  logic [POS_W-1:0] pos;

  logic             adv;
  logic             is_stream;
  logic [NUM_SLOTS-1:0] match_next;
  logic             zl_any;
  logic [SLOT_W-1:0] zl_slot;

  logic             b_valid;
  logic             b_last;
  logic [POS_W-1:0] b_pos;
  logic [NUM_SLOTS-1:0] b_match;
  logic [LEN_W-1:0] b_len [NUM_SLOTS];
  logic             b_zl_valid;
  logic [SLOT_W-1:0] b_zl_slot;

  logic [LEN_W-1:0] top_len;
  logic [SLOT_W-1:0] sel_slot;
  logic [OFF_W-1:0] sel_off;

  logic             c_valid;
  logic             c_last;
  logic             c_cand;
  logic [SLOT_W-1:0] c_slot;
  logic [OFF_W-1:0] c_off;
  logic             c_zl_valid;
  logic [SLOT_W-1:0] c_zl_slot;

  logic             best_found;
  logic [SLOT_W-1:0] best_slot;
  logic [OFF_W-1:0] best_offset;
  logic             t1_found;
  logic [SLOT_W-1:0] t1_slot;
  logic [OFF_W-1:0] t1_off;
  logic             t2_found;
  logic [SLOT_W-1:0] t2_slot;
  logic [OFF_W-1:0] t2_off;

  assign adv       = !result_valid || !result_stall;
  assign pop       = adv && q_valid;
  assign is_stream = pop && (q_cmd.kind == msfm_pkg::CMD_STREAM);

  // window after this beat's shift
  always_comb begin
    win_next[0] = q_cmd.data;
    for (int j = 1; j < MAX_SIG_LEN; j++) win_next[j] = win[j-1];
  end

  always_comb begin
    logic             ok;
    logic [LEN_W-1:0] idx;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      ok = (s < int'(cfg.pattern_count)) && (lens[s] != '0)
        && ({1'b0, pos} < (POS_W+1)'(cfg.scan_length))
        && ((POS_W+1)'(pos) + (POS_W+1)'(1) >= (POS_W+1)'(lens[s]));
      for (int k = 0; k < MAX_SIG_LEN; k++) begin
        idx = lens[s] - LEN_W'(1) - LEN_W'(k);
        if (k < int'(lens[s]) && sig[s][k] != win_next[idx[WIN_W-1:0]]) ok = 1'b0;
      end
      match_next[s] = ok;
    end
  end

  always_comb begin
    zl_any  = 1'b0;
    zl_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (s < int'(cfg.pattern_count) && lens[s] == '0) begin
        zl_any  = 1'b1;
        zl_slot = SLOT_W'(s);
      end
    end
  end

  // signature store
  always_ff @(posedge clk) begin
    if (pop && q_cmd.kind == msfm_pkg::CMD_SIG_BYTE) begin
      for (int s = 0; s < NUM_SLOTS; s++)
        for (int k = 0; k < MAX_SIG_LEN; k++)
          if (int'(q_cmd.slot) == s && int'(q_cmd.bpos) == k) sig[s][k] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) lens[s] <= '0;
      for (int j = 0; j < MAX_SIG_LEN; j++) win[j] <= '0;
      pos <= '0;
    end else begin
      if (pop && q_cmd.kind == msfm_pkg::CMD_SIG_LEN) begin
        for (int s = 0; s < NUM_SLOTS; s++)
          if (int'(q_cmd.slot) == s) lens[s] <= q_cmd.data[LEN_W-1:0];
      end
      if (is_stream) begin
        if (q_cmd.last) begin
          for (int j = 0; j < MAX_SIG_LEN; j++) win[j] <= '0;
          pos <= '0;
        end else begin
          for (int j = 0; j < MAX_SIG_LEN; j++) win[j] <= win_next[j];
          if (pos != msfm_pkg::POS_MAX) pos <= pos + POS_W'(1);
        end
      end
    end
  end

  // stage B: compare results
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= is_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_last     <= q_cmd.last;
      b_pos      <= pos;
      b_match    <= match_next;
      b_zl_valid <= zl_any && (cfg.scan_length != '0);
      b_zl_slot  <= zl_slot;
      for (int s = 0; s < NUM_SLOTS; s++) b_len[s] <= lens[s];
    end
  end

  // longest match starts earliest; lowest slot among those
  always_comb begin
    logic hit;
    top_len = '0;
    for (int l = 1; l <= MAX_SIG_LEN; l++) begin
      hit = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++)
        if (b_match[s] && int'(b_len[s]) == l) hit = 1'b1;
      if (hit) top_len = LEN_W'(l);
    end
    sel_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--)
      if (b_match[s] && b_len[s] == top_len) sel_slot = SLOT_W'(s);
    sel_off = OFF_W'(b_pos + POS_W'(1) - POS_W'(top_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_last     <= b_last;
      c_cand     <= |b_match;
      c_slot     <= sel_slot;
      c_off      <= sel_off;
      c_zl_valid <= b_zl_valid;
      c_zl_slot  <= b_zl_slot;
    end
  end

  // stage C: merge into best, report on last beat
  always_comb begin
    t1_found = best_found;
    t1_slot  = best_slot;
    t1_off   = best_offset;
    if (c_cand && (!best_found || c_off < best_offset
        || (c_off == best_offset && c_slot < best_slot))) begin
      t1_found = 1'b1;
      t1_slot  = c_slot;
      t1_off   = c_off;
    end
    t2_found = t1_found;
    t2_slot  = t1_slot;
    t2_off   = t1_off;
    if (c_last && c_zl_valid && (!t1_found || t1_off != '0
        || c_zl_slot < t1_slot)) begin
      t2_found = 1'b1;
      t2_slot  = c_zl_slot;
      t2_off   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found   <= 1'b0;
      best_slot    <= '0;
      best_offset  <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= c_valid && c_last;
      if (c_valid) begin
        if (c_last) begin
          best_found  <= 1'b0;
          best_slot   <= '0;
          best_offset <= '0;
        end else begin
          best_found  <= t1_found;
          best_slot   <= t1_slot;
          best_offset <= t1_off;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_valid && c_last) begin
      result.found        <= t2_found;
      result.match_slot   <= msfm_pkg::SLOT_FIELD_W'(t2_slot);
      result.match_offset <= t2_off;
    end
  end

  a_best_clear: assert property (@(posedge clk) disable iff (rst)
    !best_found |-> best_slot == '0 && best_offset == '0)
    else $error("best slot or offset set without a match");

  a_last_clears_pos: assert property (@(posedge clk) disable iff (rst)
    is_stream && q_cmd.last |=> pos == '0)
    else $error("position not cleared after last beat");

  a_last_reports: assert property (@(posedge clk) disable iff (rst)
    adv && c_valid && c_last |=> result_valid)
    else $error("last beat gave no result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.match_slot == '0 && result.match_offset == '0)
    else $error("result without match carries slot or offset");

endmodule

// ===== sv/multi_signature_first_match_scan_unit.sv =====
// Top level of the multi-signature first-match scan unit.
//
// Usage: the item channel (item_valid, item_stall, item) carries signature byte
// writes, signature length writes and stream bytes; one beat moves per cycle
// when item_valid is high and item_stall low. The result channel (result_valid,
// result_stall, result) gives one beat for each stream byte marked last: found,
// winning slot and its start offset, or all zero when nothing matched.
// Registers pattern_count (index 0) and scan_length (index 1) are written on
// the cfg channel; cfg_ready is always high. Write them only while idle.
// Throughput: one item per cycle while item_stall is low; all slots compare
// against the byte window in parallel in a single stage. A last byte passes
// through the input register, queue, compare, winner pick and result register
// before its result shows. While result_stall holds a result, the engine halts
// and the queue fills; item_stall rises once the queue and input register are
// full. Reset clears lengths, window, position, best match and registers
// (scan_length to 0xFFFE); signature bytes are undefined until written.
module multi_signature_first_match_scan_unit #(
  parameter int NUM_SLOTS   = msfm_pkg::NUM_SLOTS_DEF,
  parameter int MAX_SIG_LEN = msfm_pkg::MAX_SIG_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  msfm_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output msfm_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  msfm_pkg::cfg_t cfg;
  logic           push_valid;
  msfm_pkg::cmd_t push_cmd;
  logic           q_ready;
  logic           q_valid;
  msfm_pkg::cmd_t q_cmd;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_count <= '0;
      cfg.scan_length   <= msfm_pkg::SCAN_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msfm_pkg::REG_PATTERN_COUNT: cfg.pattern_count <= cfg_data[5:0];
        msfm_pkg::REG_SCAN_LENGTH:   cfg.scan_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  msfm_front #(.NUM_SLOTS(NUM_SLOTS), .MAX_SIG_LEN(MAX_SIG_LEN)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_ready    (q_ready)
  );

  msfm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push_valid),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .valid    (q_valid),
    .data     (q_cmd),
    .pop      (pop)
  );

  msfm_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_SIG_LEN(MAX_SIG_LEN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== test/multi_signature_first_match_scan_unit_tb.sv =====
// Testbench of the multi-signature first-match scan unit: directed table, then random phases.
`timescale 1ns / 100ps

module multi_signature_first_match_scan_unit_tb;

  localparam int SLOTS = 32;
  localparam int SIG_LEN = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int IN_W = $bits(msfm_pkg::in_item_t);
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    bit        is_cfg;
    logic      cfg_idx;
    logic [15:0] cfg_val;
    msfm_pkg::in_item_t  it;
    bit        fixed;
    msfm_pkg::out_item_t want;
  } row_t;

  logic clk, rst;
  logic item_valid, item_stall;
  msfm_pkg::in_item_t item;
  logic result_valid, result_stall;
  msfm_pkg::out_item_t result;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;

  logic [7:0]  sig_mem [SLOTS][SIG_LEN];
  bit          sig_written [SLOTS][SIG_LEN];
  logic [4:0]  sig_len [SLOTS];
  logic [7:0]  window [SIG_LEN];
  int          stream_pos;
  bit          best_found;
  int          best_slot, best_offset;
  int          slot_count, scan_limit;

  msfm_pkg::out_item_t expected_q [$];
  row_t        table_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          items_sent;
  bit          gaps_on;

  logic [15:0] limits [6] = '{16'hFFFF, 16'd0, 16'd12, 16'hFFFE, 16'd300, 16'd40};
  logic [15:0] counts [6] = '{16'd32, 16'd63, 16'd0, 16'd1, 16'd9, 16'd20};

  multi_signature_first_match_scan_unit DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic msfm_pkg::in_item_t mk(logic [1:0] f, int s, int p, int d, bit l);
    msfm_pkg::in_item_t r;
    r.func = f;
    r.slot = 5'(s);
    r.byte_position = 4'(p);
    r.data_byte = 8'(d);
    r.last = l;
    return r;
  endfunction

  function automatic msfm_pkg::out_item_t mk_out(bit f, int s, int o);
    msfm_pkg::out_item_t r;
    r.found = f;
    r.match_slot = 5'(s);
    r.match_offset = 16'(o);
    return r;
  endfunction

  function automatic int written_prefix(int s);
    int k;
    for (k = 0; k < SIG_LEN; k++) if (!sig_written[s][k]) return k;
    return SIG_LEN;
  endfunction

  function automatic void clear_scan();
    foreach (window[k]) window[k] = 8'h00;
    stream_pos = 0;
    best_found = 0;
    best_slot = 0;
    best_offset = 0;
  endfunction

  function automatic void offer_match(int s, int off);
    if (!best_found || off < best_offset || (off == best_offset && s < best_slot)) begin
      best_found = 1;
      best_slot = s;
      best_offset = off;
    end
  endfunction

  // advance the scan state by one beat; returns 1 when a result is due
  function automatic bit scan_step(msfm_pkg::in_item_t it, output msfm_pkg::out_item_t res);
    int n, s, k, len;
    bit hit;
    res = '0;
    case (it.func)
      msfm_pkg::FUNC_SIG_BYTE: begin
        sig_mem[it.slot][it.byte_position] = it.data_byte;
        sig_written[it.slot][it.byte_position] = 1;
      end
      msfm_pkg::FUNC_SIG_LEN:
        sig_len[it.slot] = (it.data_byte > SIG_LEN) ? 5'(SIG_LEN) : it.data_byte[4:0];
      msfm_pkg::FUNC_STREAM: begin
        for (k = SIG_LEN - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = it.data_byte;
        n = (slot_count > SLOTS) ? SLOTS : slot_count;
        if (stream_pos < scan_limit) begin
          for (s = 0; s < n; s++) begin
            len = sig_len[s];
            if (len == 0 || stream_pos + 1 < len) continue;
            hit = 1;
            for (k = 0; k < len; k++) if (sig_mem[s][k] != window[len-1-k]) hit = 0;
            if (hit) offer_match(s, stream_pos + 1 - len);
          end
        end
        if (stream_pos < msfm_pkg::POS_MAX) stream_pos++;
        if (it.last) begin
          if (scan_limit > 0) begin
            for (s = 0; s < n; s++) if (sig_len[s] == 0) begin
              offer_match(s, 0);
              break;
            end
          end
          if (best_found) res = mk_out(1, best_slot, best_offset);
          clear_scan();
          return 1;
        end
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic send(msfm_pkg::in_item_t it, bit fixed, msfm_pkg::out_item_t want);
    msfm_pkg::out_item_t res;
    while (gaps_on && $urandom_range(99) < 28) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item <= it;
    do @(posedge clk); while (item_stall);
    if (scan_step(it, res)) expected_q.push_back(fixed ? want : res);
    if (it.func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    item_valid <= 0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == msfm_pkg::REG_PATTERN_COUNT) slot_count = val[5:0];
    else scan_limit = val;
  endtask

  always @(posedge clk) begin
    msfm_pkg::out_item_t e;
    if (rst) begin
      result_stall <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (result.found !== e.found) begin
            $display("%0t: found exp %0d got %0d", $time, e.found, result.found);
            errors++;
          end
          if (result.match_slot !== e.match_slot) begin
            $display("%0t: slot exp %0d got %0d", $time, e.match_slot, result.match_slot);
            errors++;
          end
          if (result.match_offset !== e.match_offset) begin
            $display("%0t: offset exp %0d got %0d", $time, e.match_offset,
                     result.match_offset);
            errors++;
          end
        end
      end
      result_stall <= gaps_on && ($urandom_range(99) < 28);
    end
  end

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) < 8) return 8'(8'h41 + $urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_item(msfm_pkg::in_item_t it, bit fixed = 0,
                                   msfm_pkg::out_item_t want = '0);
    row_t r;
    r = '{default: '0};
    r.it = it;
    r.fixed = fixed;
    r.want = want;
    table_q.push_back(r);
  endfunction

  function automatic void add_cfg(logic idx, logic [15:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    table_q.push_back(r);
  endfunction

  task automatic load_signature(int s);
    int len, k;
    len = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(1, 5);
    for (k = 0; k < len; k++)
      send(mk(msfm_pkg::FUNC_SIG_BYTE, s, k, pick_byte(), 0), 0, '0);
    if (len == SIG_LEN && $urandom_range(1)) len = $urandom_range(16, 255);
    send(mk(msfm_pkg::FUNC_SIG_LEN, s, 0, len, 0), 0, '0);
  endtask

  task automatic send_stream(int n);
    logic [7:0] bytes [$];
    int k, s, at;
    for (k = 0; k < n; k++) bytes.push_back(pick_byte());
    s = $urandom_range(SLOTS - 1);
    if ($urandom_range(1) && sig_len[s] > 0) begin
      at = $urandom_range(bytes.size());
      for (k = sig_len[s] - 1; k >= 0; k--) bytes.insert(at, sig_mem[s][k]);
    end
    for (k = 0; k < bytes.size(); k++)
      send(mk(msfm_pkg::FUNC_STREAM, $urandom_range(31), $urandom_range(15), bytes[k],
              k == bytes.size() - 1), 0, '0);
  endtask

  task automatic send_noise();
    msfm_pkg::in_item_t it;
    int pre;
    it = IN_W'($urandom);
    if (it.func == msfm_pkg::FUNC_SIG_LEN) begin
      pre = written_prefix(it.slot);
      if (pre < SIG_LEN) it.data_byte = 8'($urandom_range(pre));
    end
    send(it, 0, '0);
  endtask

  initial begin
    row_t r;
    int ph, op, goal;
    rst = 1;
    item_valid = 0;
    item = '0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    items_sent = 0;
    gaps_on = 1;
    foreach (sig_len[s]) sig_len[s] = 0;
    foreach (sig_mem[s, k]) begin
      sig_mem[s][k] = 0;
      sig_written[s][k] = 0;
    end
    clear_scan();
    slot_count = 0;
    scan_limit = msfm_pkg::SCAN_LENGTH_RESET;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hFF, 1), 1, mk_out(0, 0, 0));
    add_cfg(msfm_pkg::REG_PATTERN_COUNT, 16'd4);
    add_item(mk(msfm_pkg::FUNC_STREAM, 31, 15, 8'h00, 1), 1, mk_out(1, 0, 0));
    add_item(mk(msfm_pkg::FUNC_SIG_BYTE, 0, 0, 8'hAB, 0));
    add_item(mk(msfm_pkg::FUNC_SIG_BYTE, 0, 1, 8'hCD, 0));
    add_item(mk(msfm_pkg::FUNC_SIG_LEN, 0, 0, 8'd2, 0));
    add_item(mk(msfm_pkg::FUNC_SIG_BYTE, 1, 0, 8'hCD, 0));
    add_item(mk(msfm_pkg::FUNC_SIG_LEN, 1, 0, 8'd1, 0));
    add_item(mk(msfm_pkg::FUNC_SIG_BYTE, 31, 15, 8'hFF, 0));
    add_item(mk(FUNC_UNUSED, 31, 15, 8'hFF, 1));
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hCD, 0));
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hAB, 0));
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hCD, 1));
    add_cfg(msfm_pkg::REG_SCAN_LENGTH, 16'd0);
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hCD, 1), 1, mk_out(0, 0, 0));
    add_cfg(msfm_pkg::REG_SCAN_LENGTH, 16'd2);
    add_cfg(msfm_pkg::REG_PATTERN_COUNT, 16'd2);
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'h00, 0));
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hAB, 0));
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hCD, 1), 1, mk_out(0, 0, 0));
    add_cfg(msfm_pkg::REG_SCAN_LENGTH, 16'hFFFF);
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hCD, 1), 1, mk_out(1, 1, 0));
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hAB, 0));
    add_item(mk(msfm_pkg::FUNC_STREAM, 0, 0, 8'hCD, 1));

    foreach (table_q[i]) begin
      r = table_q[i];
      if (r.is_cfg) write_reg(r.cfg_idx, r.cfg_val);
      else send(r.it, r.fixed, r.want);
    end

    for (ph = 0; ph < 8; ph++) begin
      write_reg(msfm_pkg::REG_PATTERN_COUNT,
                (ph < 6) ? counts[ph] : 16'($urandom_range(63)));
      write_reg(msfm_pkg::REG_SCAN_LENGTH,
                (ph < 6) ? limits[ph] : 16'($urandom_range(65535)));
      gaps_on = (ph != 3);
      goal = items_sent + 130;
      while (items_sent < goal) begin
        op = $urandom_range(99);
        if (op < 30) load_signature($urandom_range(1) ? $urandom_range(7) : $urandom_range(31));
        else if (op < 80) send_stream($urandom_range(1, 30));
        else send_noise();
      end
    end

    item_valid <= 0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
